// ===== design/lts_pkg.sv =====
// lts_pkg: shared types and constants of the lottery task select block.
// Used by lts_mod_pipe and lottery_task_select_top; no dependencies.
package lts_pkg;

  // Task and register counts
  localparam int TASK_COUNT   = 4;
  localparam int REG_COUNT    = 4;
  localparam int ACTIVE_TASKS = (TASK_COUNT < REG_COUNT) ? TASK_COUNT : REG_COUNT;

  // Field widths
  localparam int TICKET_W  = 16;
  localparam int SUM_W     = 18;
  localparam int DRAW_W    = 15;
  localparam int TASK_W    = 2;
  localparam int MASK_W    = 4;
  localparam int CFG_IDX_W = 2;

  // Modulo pipeline shape: MOD_STAGES * STEPS_PER_STAGE covers every draw bit
  localparam int STEPS_PER_STAGE = 3;
  localparam int MOD_STAGES      = DRAW_W / STEPS_PER_STAGE;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKETS_TASK0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKETS_TASK1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKETS_TASK2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKETS_TASK3 = 2'd3;

  // Ticket counts after reset
  localparam logic [TICKET_W-1:0] TICKETS_RST [REG_COUNT] = '{
    16'd1, 16'd100, 16'd10, 16'd400
  };

  // Result of the modulo pipeline handed to the selection stage
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] rem;
  } lts_mod_res_t;

endpackage

// ===== design/lts_mod_pipe.sv =====
// lts_mod_pipe: pipelined restoring modulo, draw mod ticket total.
// Depends on lts_pkg; three remainder steps per register stage.
module lts_mod_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [lts_pkg::DRAW_W-1:0] in_random_value,
  input  logic [lts_pkg::SUM_W-1:0]  total,
  output lts_pkg::lts_mod_res_t      mod_res
);

  localparam int SW = lts_pkg::SUM_W;
  localparam int NS = lts_pkg::MOD_STAGES;
  localparam int SP = lts_pkg::STEPS_PER_STAGE;
  localparam int DW = lts_pkg::DRAW_W;

  // A group of restoring steps, draw bits taken MSB first
  function automatic logic [SW-1:0] mod_steps(input logic [SW-1:0] rem,
                                              input logic [SP-1:0] bits,
                                              input logic [SW-1:0] tot);
    logic [SW:0]   r;
    logic [SW-1:0] acc;
    acc = rem;
    for (int k = SP - 1; k >= 0; k--) begin
      r = {acc, bits[k]};
      if (r >= {1'b0, tot}) begin
        r = r - {1'b0, tot};
      end
      acc = r[SW-1:0];
    end
    return acc;
  endfunction

  logic          valid_r [NS];
  logic [SW-1:0] rem_r   [NS];
  logic [DW-1:0] draw_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          valid_in;
    logic [SW-1:0] rem_in;
    logic [DW-1:0] draw_in;
    logic [SW-1:0] rem_nxt;

    // stage inputs: first stage starts from a zero remainder
    if (s == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = '0;
      assign draw_in  = in_random_value;
    end else begin : g_next
      assign valid_in = valid_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign draw_in  = draw_r[s-1];
    end

    assign rem_nxt = mod_steps(rem_in, draw_in[DW-1-SP*s -: SP], total);

    // valid bit travels with the data
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (adv) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_nxt;
        draw_r[s] <= draw_in;
      end
    end
  end

  assign mod_res.valid = valid_r[NS-1];
  assign mod_res.rem   = rem_r[NS-1];

endmodule

// ===== design/lottery_task_select_top.sv =====
// Pipeline: five modulo stages of three restoring steps over the 15-bit draw, then
// selection in the output register;
// throughput one request per cycle, fully pipelined; a held result stalls it all.
// Ticket prefix sums are registered from the ticket registers after a write.
// Reset (synchronous, active low) clears all valid bits and loads the ticket
// counts 1, 100, 10, 400.
// lottery_task_select_top: depends on lts_pkg and lts_mod_pipe.
module lottery_task_select_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lts_pkg::DRAW_W-1:0]    in_random_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lts_pkg::TASK_W-1:0]    out_chosen_task,
  output logic [lts_pkg::MASK_W-1:0]    out_running_mask,
  output logic                          out_no_tickets,
  // configuration
  input  logic                          cfg_we,
  input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lts_pkg::TICKET_W-1:0]  cfg_wdata
);

  localparam int SW = lts_pkg::SUM_W;
  localparam int RC = lts_pkg::REG_COUNT;
  localparam int AT = lts_pkg::ACTIVE_TASKS;

  logic [lts_pkg::TICKET_W-1:0] tickets_r [RC];
  logic [SW-1:0]                psum_r    [RC];
  logic [SW-1:0]                psum_nxt  [RC];
  logic                         adv;
  lts_pkg::lts_mod_res_t        mod_res;

  logic                         out_valid_r;
  logic [lts_pkg::TASK_W-1:0]   chosen_r, chosen_nxt;
  logic [lts_pkg::MASK_W-1:0]   mask_r, mask_nxt;
  logic                         none_r, none_nxt;

  // ticket registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RC; i++) begin
        tickets_r[i] <= lts_pkg::TICKETS_RST[i];
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        lts_pkg::REG_TICKETS_TASK0: tickets_r[0] <= cfg_wdata;
        lts_pkg::REG_TICKETS_TASK1: tickets_r[1] <= cfg_wdata;
        lts_pkg::REG_TICKETS_TASK2: tickets_r[2] <= cfg_wdata;
        lts_pkg::REG_TICKETS_TASK3: tickets_r[3] <= cfg_wdata;
      endcase
    end
  end

  // running ticket sums; tasks past the active count hold none
  always_comb begin
    logic [SW-1:0] acc;
    acc = '0;
    for (int i = 0; i < RC; i++) begin
      if (i < AT) begin
        acc = acc + SW'(tickets_r[i]);
      end
      psum_nxt[i] = acc;
    end
  end

  always_ff @(posedge clk) begin
    psum_r <= psum_nxt;
  end

  // whole pipeline moves unless a finished result is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  lts_mod_pipe u_mod (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_random_value (in_random_value),
    .total           (psum_r[AT-1]),
    .mod_res         (mod_res)
  );

  // selection: first task whose running sum exceeds the remainder
  always_comb begin
    chosen_nxt = '0;
    for (int i = AT - 1; i >= 0; i--) begin
      if (psum_r[i] > mod_res.rem) begin
        chosen_nxt = lts_pkg::TASK_W'(i);
      end
    end
    none_nxt = (psum_r[AT-1] == '0);
    mask_nxt = none_nxt ? '0 : (lts_pkg::MASK_W'(1) << chosen_nxt);
    if (none_nxt) begin
      chosen_nxt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mod_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mod_res.valid) begin
      chosen_r <= chosen_nxt;
      mask_r   <= mask_nxt;
      none_r   <= none_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_task  = chosen_r;
  assign out_running_mask = mask_r;
  assign out_no_tickets   = none_r;

  // mask agrees with the task index on a real pick
  a_mask_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !none_r |-> $onehot(mask_r) &&
      mask_r == (lts_pkg::MASK_W'(1) << chosen_r))
    else $error("running mask does not match chosen task");

  // a held result freezes the modulo pipeline output
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(mod_res))
    else $error("pipeline moved while result was held");

  // a finished remainder always reaches the output register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    mod_res.valid && adv |=> out_valid_r)
    else $error("pipeline request lost at selection stage");

endmodule

// ===== dv/lts_checker.sv =====
// lts_checker: watches the request, result and configuration ports of
// lottery_task_select_top, predicts each pick and compares it. Depends on lts_pkg.
`timescale 1ns / 1ps
module lts_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lts_pkg::DRAW_W-1:0]    in_random_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lts_pkg::TASK_W-1:0]    out_chosen_task,
  input  logic [lts_pkg::MASK_W-1:0]    out_running_mask,
  input  logic                          out_no_tickets,
  input  logic                          cfg_we,
  input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lts_pkg::TICKET_W-1:0]  cfg_wdata,
  output int                            fail_count,
  output int                            outstanding
);
  import lts_pkg::*;

  typedef struct packed {
    logic [TASK_W-1:0] chosen;
    logic [MASK_W-1:0] mask;
    logic              no_tickets;
  } lottery_pick_t;

  // Shadow copy of the ticket registers
  logic [TICKET_W-1:0] tickets [REG_COUNT];
  lottery_pick_t       pending_picks [$];

  // Sum the tickets, form the winning ticket and walk the running total
  function automatic lottery_pick_t draw_winner(input logic [DRAW_W-1:0] draw);
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] running;
    logic [SUM_W-1:0] winning;
    lottery_pick_t    pick;
    logic             found;
    total   = '0;
    running = '0;
    pick    = '0;
    found   = 1'b0;
    for (int i = 0; i < ACTIVE_TASKS; i++) total += SUM_W'(tickets[i]);
    if (total == '0) begin
      pick.no_tickets = 1'b1;
    end else begin
      winning = (SUM_W'(draw) % total) + SUM_W'(1);
      for (int i = 0; i < ACTIVE_TASKS; i++) begin
        if (!found) begin
          running += SUM_W'(tickets[i]);
          if (running >= winning) begin
            pick.chosen = TASK_W'(i);
            pick.mask   = MASK_W'(1) << i;
            found       = 1'b1;
          end
        end
      end
    end
    return pick;
  endfunction

  always @(posedge clk) begin : monitor
    lottery_pick_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) tickets[i] <= TICKETS_RST[i];
      pending_picks.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      // the user must make register writes only while the block is idle; nothing enforces it
      if (cfg_we) begin
        case (cfg_index)
          REG_TICKETS_TASK0: tickets[0] <= cfg_wdata;
          REG_TICKETS_TASK1: tickets[1] <= cfg_wdata;
          REG_TICKETS_TASK2: tickets[2] <= cfg_wdata;
          REG_TICKETS_TASK3: tickets[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_picks.push_back(draw_winner(in_random_value));
      // compare each accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_picks.size() == 0) begin
          $display("%0t: unexpected result task=%0d mask=%b none=%b", $time,
                   out_chosen_task, out_running_mask, out_no_tickets);
          errs++;
        end else begin
          want = pending_picks.pop_front();
          if (out_chosen_task !== want.chosen) begin
            $display("%0t: chosen_task expected %0d, got %0d", $time, want.chosen,
                     out_chosen_task);
            errs++;
          end
          if (out_running_mask !== want.mask) begin
            $display("%0t: running_mask expected %b, got %b", $time, want.mask,
                     out_running_mask);
            errs++;
          end
          if (out_no_tickets !== want.no_tickets) begin
            $display("%0t: no_tickets expected %b, got %b", $time, want.no_tickets,
                     out_no_tickets);
            errs++;
          end
        end
      end
      fail_count  <= fail_count + errs;
      outstanding <= pending_picks.size();
    end
  end

endmodule

// ===== dv/lottery_task_select_top_tb.sv =====
// lottery_task_select_top_tb: drives requests and ticket settings into
// lottery_task_select_top and reports the verdict. Depends on lts_pkg, lts_checker.
`timescale 1ns / 1ps
module lottery_task_select_top_tb;
  import lts_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 32;
  localparam int DRAWS_PER_PHASE = 30;
  localparam int QUIET_PHASES    = 6;
  localparam int SETTLE_CYCLES   = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DRAW_W-1:0]    in_random_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TASK_W-1:0]    out_chosen_task;
  logic [MASK_W-1:0]    out_running_mask;
  logic                 out_no_tickets;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TICKETS_TASK0;
  logic [TICKET_W-1:0]  cfg_wdata = '0;

  logic                 idle_on = 1'b0;
  int                   stall_left = 0;
  int                   quiet_cycles = 0;
  int                   fail_count;
  int                   outstanding;
  logic [TICKET_W-1:0]  cur_tickets [REG_COUNT];

  always #4 clk = ~clk;

  lottery_task_select_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_task  (out_chosen_task),
    .out_running_mask (out_running_mask),
    .out_no_tickets   (out_no_tickets),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  lts_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_task  (out_chosen_task),
    .out_running_mask (out_running_mask),
    .out_no_tickets   (out_no_tickets),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // Result-side back-pressure in bursts of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lottery_task_select_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write all four ticket registers, block idle
  task automatic program_tickets(input logic [TICKET_W-1:0] t0, input logic [TICKET_W-1:0] t1,
                                 input logic [TICKET_W-1:0] t2, input logic [TICKET_W-1:0] t3);
    cur_tickets[0] = t0;
    cur_tickets[1] = t1;
    cur_tickets[2] = t2;
    cur_tickets[3] = t3;
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICKETS_TASK0;
    cfg_wdata <= t0;
    @(posedge clk);
    cfg_index <= REG_TICKETS_TASK1;
    cfg_wdata <= t1;
    @(posedge clk);
    cfg_index <= REG_TICKETS_TASK2;
    cfg_wdata <= t2;
    @(posedge clk);
    cfg_index <= REG_TICKETS_TASK3;
    cfg_wdata <= t3;
    @(posedge clk);
    cfg_we <= 1'b0;
    // prefix sums are registered from the ticket registers; let them settle
    repeat (2) @(posedge clk);
  endtask

  // One request, with an optional random gap ahead of it
  task automatic send_draw(input logic [DRAW_W-1:0] draw);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_random_value <= draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait for every predicted pick to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TICKET_W-1:0] rand_tickets();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return TICKET_W'($urandom_range(1, 20));
      2:       return TICKET_W'($urandom_range(0, 4000));
      default: return TICKET_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly uniform draws; some land right on a task boundary
  function automatic logic [DRAW_W-1:0] next_draw();
    logic [19:0] total;
    logic [19:0] prefix;
    logic [19:0] cand;
    int          j;
    total  = '0;
    prefix = '0;
    for (int i = 0; i < REG_COUNT; i++) total += 20'(cur_tickets[i]);
    if (total != 0 && $urandom_range(0, 3) == 0) begin
      j = $urandom_range(0, REG_COUNT - 1);
      for (int i = 0; i <= j; i++) prefix += 20'(cur_tickets[i]);
      if (prefix != 0) begin
        cand = prefix - 20'd1 + 20'($urandom_range(0, 1)) + total * 20'($urandom_range(0, 2));
        if (cand < 20'd32768) return cand[DRAW_W-1:0];
      end
    end
    return DRAW_W'($urandom_range(0, 32767));
  endfunction

  initial begin
    for (int i = 0; i < REG_COUNT; i++) cur_tickets[i] = TICKETS_RST[i];
    repeat (12) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk);

    // reset ticket counts 1/100/10/400: walk every boundary and the draw extremes
    send_draw(15'd0);
    send_draw(15'd1);
    send_draw(15'd100);
    send_draw(15'd101);
    send_draw(15'd110);
    send_draw(15'd111);
    send_draw(15'd510);
    send_draw(15'd511);
    send_draw(15'h7FFF);
    send_draw(15'h3FFF);
    send_draw(15'h5555);
    send_draw(15'h2AAA);
    drain();

    // zero ticket total
    program_tickets(16'd0, 16'd0, 16'd0, 16'd0);
    send_draw(15'd0);
    send_draw(15'h7FFF);
    send_draw(15'h5555);
    drain();

    // every register at its maximum
    program_tickets(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_draw(15'd0);
    send_draw(15'h7FFF);
    drain();

    // a single task holding all tickets, then two tasks; zero-ticket tasks skipped
    program_tickets(16'd0, 16'd0, 16'd0, 16'd1);
    send_draw(15'd0);
    send_draw(15'h7FFF);
    drain();
    program_tickets(16'd0, 16'd0, 16'd1, 16'd0);
    send_draw(15'h2AAA);
    drain();
    program_tickets(16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_draw(15'd5);
    drain();
    program_tickets(16'd2, 16'd0, 16'd0, 16'd3);
    send_draw(15'd1);
    send_draw(15'd2);
    drain();

    // random ticket settings, some all zero, random draws; no idling near the end
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < RANDOM_PHASES - QUIET_PHASES) idle_on <= ($urandom_range(0, 4) != 0);
      else idle_on <= 1'b0;
      if (p % 11 == 5) program_tickets(16'd0, 16'd0, 16'd0, 16'd0);
      else program_tickets(rand_tickets(), rand_tickets(), rand_tickets(), rand_tickets());
      for (int n = 0; n < DRAWS_PER_PHASE; n++) send_draw(next_draw());
      drain();
    end

    if (fail_count == 0) begin
      $display("lottery_task_select_top test passed");
    end else begin
      $display("lottery_task_select_top test failed");
    end
    $finish;
  end

endmodule
